// ----- src/nstf_pkg.sv -----
// ============================================================================
// NMEA sentence type filter package
// Shared types, character codes and the sentence prefix table.
// ============================================================================
package nstf_pkg;

    localparam int PREFIX_LEN = 5;

    localparam logic [7:0] C_CH_DOLLAR = 8'h24;
    localparam logic [7:0] C_CH_LF     = 8'h0A;
    localparam logic [7:0] C_CH_CR     = 8'h0D;

    typedef enum logic [2:0] {
        TYPE_GGA = 3'd0,
        TYPE_GLL = 3'd1,
        TYPE_GSA = 3'd2,
        TYPE_GSV = 3'd3,
        TYPE_RMC = 3'd4,
        TYPE_VTG = 3'd5,
        TYPE_MSS = 3'd6,
        TYPE_ZDA = 3'd7
    } t_sentence_type;

    typedef logic [PREFIX_LEN*8-1:0] t_prefix;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_sentence;
        logic       line_end;
        logic       match;
        logic       found;
    } t_result;

    // The five characters after the dollar, first character in the top byte.
    function automatic t_prefix f_type_prefix(input t_sentence_type t);
        t_prefix p;
        unique case (t)
            TYPE_GGA: p = "GPGGA";
            TYPE_GLL: p = "GPGLL";
            TYPE_GSA: p = "GPGSA";
            TYPE_GSV: p = "GPGSV";
            TYPE_RMC: p = "GPRMC";
            TYPE_VTG: p = "GPVTG";
            TYPE_MSS: p = "GPMSS";
            TYPE_ZDA: p = "GPZDA";
            default:  p = "GPGGA";
        endcase
        return p;
    endfunction

endpackage

// ----- src/nstf_parser.sv -----
// ============================================================================
// NMEA sentence parser
// Holds the framing state and prefix characters, and computes the result
// word for the current input byte.
// ============================================================================
module nstf_parser (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_restart,
    input  nstf_pkg::t_sentence_type i_wanted_type,
    output nstf_pkg::t_result       o_result
);
    import nstf_pkg::*;

    localparam int CNT_W = $clog2(PREFIX_LEN + 1);
    localparam int IDX_W = $clog2(PREFIX_LEN);

    logic             r_reading;
    logic             n_reading;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_found;
    logic             n_found;
    logic [7:0]       r_prefix [PREFIX_LEN];

    logic             reading_e;
    logic [CNT_W-1:0] count_e;
    logic             found_e;
    logic             store_char;
    logic             full;
    logic             prefix_equal;
    t_prefix          held;

    always_comb begin
        for (int i = 0; i < PREFIX_LEN; i++) begin
            held[(PREFIX_LEN-1-i)*8 +: 8] = r_prefix[i];
        end
    end

    assign reading_e    = i_restart ? 1'b0 : r_reading;
    assign count_e      = i_restart ? '0 : r_count;
    assign found_e      = i_restart ? 1'b0 : r_found;
    assign full         = (count_e == CNT_W'(PREFIX_LEN));
    assign prefix_equal = (held == f_type_prefix(i_wanted_type));

    always_comb begin
        n_reading            = reading_e;
        n_count              = count_e;
        n_found              = found_e;
        store_char           = 1'b0;
        o_result.out_byte    = i_rx_byte;
        o_result.in_sentence = 1'b0;
        o_result.line_end    = 1'b0;
        o_result.match       = 1'b0;
        if (i_rx_byte == C_CH_DOLLAR) begin
            n_reading            = 1'b1;
            n_count              = '0;
            o_result.in_sentence = 1'b1;
        end else if (i_rx_byte == C_CH_LF || i_rx_byte == C_CH_CR) begin
            if (reading_e) begin
                o_result.line_end = 1'b1;
                o_result.match    = full && prefix_equal;
                n_found           = found_e || (full && prefix_equal);
                n_reading         = 1'b0;
            end
        end else if (reading_e) begin
            o_result.in_sentence = 1'b1;
            if (!full) begin
                store_char = 1'b1;
                n_count    = count_e + CNT_W'(1);
            end
        end
        o_result.found = n_found;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_count   <= '0;
            r_found   <= 1'b0;
        end else if (i_accept) begin
            r_reading <= n_reading;
            r_count   <= n_count;
            r_found   <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && store_char) begin
            r_prefix[count_e[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PREFIX_LEN))
        else $error("prefix count out of range");

    a_found_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(r_found) && !$past(i_accept && i_restart) |-> r_found)
        else $error("found flag dropped without restart");

    a_match_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.match |-> full && reading_e)
        else $error("match without a full prefix in a sentence");

endmodule

// ----- src/nmea_sentence_type_filter_top.sv -----
// ============================================================================
// NMEA sentence type filter
// Frames NMEA sentences from received bytes and flags sentences whose
// prefix equals the selected type.
// ============================================================================
//
//  Channel  Direction  Handshake                 Word
//  cfg      in         i_cfg_valid / o_cfg_ready i_cfg_wanted_type
//  in       in         i_in_valid / o_in_ready   i_rx_byte, i_restart
//  out      out        o_out_valid / i_out_ready o_out_byte .. o_found
//
// Each accepted byte's result is loaded into the output register on the
// next cycle; one byte is accepted every cycle unless the output stalls.
// The input is ready whenever the output register is empty or being taken.
// Synchronous reset clears the framing state, found flag and selected type.
// The configuration port is always ready.
module nmea_sentence_type_filter_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_wanted_type,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    input  logic       i_restart,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_in_sentence,
    output logic       o_line_end,
    output logic       o_match,
    output logic       o_found
);
    import nstf_pkg::*;

    t_sentence_type r_wanted_type;
    logic           r_out_valid;
    t_result        r_result;
    t_result        n_result;
    logic           in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted_type <= TYPE_GGA;
        end else if (i_cfg_valid) begin
            r_wanted_type <= t_sentence_type'(i_cfg_wanted_type);
        end
    end

    nstf_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_rx_byte     (i_rx_byte),
        .i_restart     (i_restart),
        .i_wanted_type (r_wanted_type),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_result.out_byte;
    assign o_in_sentence = r_result.in_sentence;
    assign o_line_end    = r_result.line_end;
    assign o_match       = r_result.match;
    assign o_found       = r_result.found;

    a_match_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_match |-> o_line_end && o_found)
        else $error("match outside a line end or without found");

    a_end_not_member: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_line_end |-> !o_in_sentence)
        else $error("line end marked as sentence member");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_out_valid && o_out_byte == $past(i_rx_byte))
        else $error("accepted byte not presented");

endmodule
